[rtl/core/rpc_frame_deframer_macros.svh]
// ----------------------------------------------------------------------------
// rpc_frame_deframer_macros
// assertion macros used by rpc_frame_deframer; expects clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_MACROS_SVH
`define RPC_FRAME_DEFRAMER_MACROS_SVH

// condition must hold on every clock out of reset
`define RPCD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RPCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent on the next cycle
`define RPCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rpcd_pkg.sv]
// ----------------------------------------------------------------------------
// rpcd_pkg
// types and constants of the rpc frame deframer
// ----------------------------------------------------------------------------
package rpcd_pkg;

  localparam int HDR_BYTES  = 34;
  localparam int CNT_W      = $clog2(HDR_BYTES);

  // header byte offsets
  localparam int OFS_MAGIC   = 0;
  localparam int OFS_VERSION = 4;
  localparam int OFS_TYPE    = 5;
  localparam int OFS_SERIAL  = 6;
  localparam int OFS_STATUS  = 8;
  localparam int OFS_METHOD  = 10;
  localparam int OFS_PAYLOAD = 14;
  localparam int OFS_TIMEOUT = 18;
  localparam int OFS_REQID   = 26;

  // configuration register indexes
  localparam logic [2:0] CFG_MAGIC     = 3'd0;
  localparam logic [2:0] CFG_VERSION   = 3'd1;
  localparam logic [2:0] CFG_TYPE      = 3'd2;
  localparam logic [2:0] CFG_MODE      = 3'd3;
  localparam logic [2:0] CFG_MAX_METH  = 3'd4;
  localparam logic [2:0] CFG_MAX_PAYLD = 3'd5;
  localparam logic [2:0] CFG_SERIAL_A  = 3'd6;
  localparam logic [2:0] CFG_SERIAL_B  = 3'd7;

  // configuration reset values
  localparam logic [31:0] RST_MAGIC     = 32'd0;
  localparam logic [7:0]  RST_VERSION   = 8'd1;
  localparam logic [7:0]  RST_TYPE      = 8'd0;
  localparam logic        RST_MODE      = 1'b0;
  localparam logic [31:0] RST_MAX_METH  = 32'd256;
  localparam logic [31:0] RST_MAX_PAYLD = 32'd65536;
  localparam logic [7:0]  RST_SERIAL_A  = 8'd0;
  localparam logic [7:0]  RST_SERIAL_B  = 8'd1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_METHOD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_METHOD  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_MAGIC   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_TYPE    = 3'd3,
    ERR_SERIAL  = 3'd4,
    ERR_METHOD  = 3'd5,
    ERR_PAYLOAD = 3'd6
  } err_t;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  version_code;
    logic [7:0]  expected_type;
    logic        mode;
    logic [31:0] max_method_len;
    logic [31:0] max_payload_len;
    logic [7:0]  serial_code_a;
    logic [7:0]  serial_code_b;
  } cfg_t;

  // from top to header unit
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } hdr_wr_t;

  // decoded and checked header, valid with the final header word
  typedef struct packed {
    err_t        err;
    logic [63:0] call_id;
    logic [31:0] deadline;
    logic [15:0] reply_status;
    logic [7:0]  serial_type;
    logic [31:0] method_len;
    logic [31:0] payload_len;
  } hdr_res_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error_code;
    logic [7:0]  out_byte;
    logic        last;
    logic [63:0] call_id;
    logic [31:0] deadline;
    logic [15:0] reply_status;
    logic [7:0]  serial_type;
    logic [31:0] method_len;
    logic [31:0] payload_len;
  } res_t;

endpackage

[rtl/core/rpcd_in_if.sv]
// ----------------------------------------------------------------------------
// rpcd_in_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
interface rpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/core/rpcd_out_if.sv]
// ----------------------------------------------------------------------------
// rpcd_out_if
// result channel out of the deframer
// ----------------------------------------------------------------------------
interface rpcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [7:0]  out_byte;
  logic        last;
  logic [63:0] call_id;
  logic [31:0] deadline;
  logic [15:0] reply_status;
  logic [7:0]  serial_type;
  logic [31:0] method_len;
  logic [31:0] payload_len;

  modport source (output valid, output kind, output error_code, output out_byte,
                  output last, output call_id, output deadline,
                  output reply_status, output serial_type, output method_len,
                  output payload_len, input ready);
  modport sink   (input valid, input kind, input error_code, input out_byte,
                  input last, input call_id, input deadline,
                  input reply_status, input serial_type, input method_len,
                  input payload_len, output ready);
endinterface

[rtl/core/rpcd_hdr.sv]
// ----------------------------------------------------------------------------
// rpcd_hdr
// header field capture and check; fields shift in big-endian as words arrive
// ----------------------------------------------------------------------------
module rpcd_hdr (
  input  logic               clk,
  input  rpcd_pkg::cfg_t     cfg,
  input  rpcd_pkg::hdr_wr_t  wr,
  output rpcd_pkg::hdr_res_t res
);

  logic [31:0] magic_r;
  logic [7:0]  version_r;
  logic [7:0]  type_r;
  logic [7:0]  serial_r;
  logic [15:0] status_r;
  logic [31:0] mlen_r;
  logic [31:0] plen_r;
  logic [31:0] tmo_r;
  logic [55:0] rid_r;
  logic        mlen_bad;

  // unused header bytes fall through the default arm
  always_ff @(posedge clk) begin
    if (wr.load) begin
      unique case (wr.idx) inside
        [rpcd_pkg::OFS_MAGIC : rpcd_pkg::OFS_VERSION - 1]: begin
          magic_r <= {magic_r[23:0], wr.data};
        end
        rpcd_pkg::OFS_VERSION: version_r <= wr.data;
        rpcd_pkg::OFS_TYPE:    type_r    <= wr.data;
        rpcd_pkg::OFS_SERIAL:  serial_r  <= wr.data;
        [rpcd_pkg::OFS_STATUS : rpcd_pkg::OFS_METHOD - 1]: begin
          status_r <= {status_r[7:0], wr.data};
        end
        [rpcd_pkg::OFS_METHOD : rpcd_pkg::OFS_PAYLOAD - 1]: begin
          mlen_r <= {mlen_r[23:0], wr.data};
        end
        [rpcd_pkg::OFS_PAYLOAD : rpcd_pkg::OFS_TIMEOUT - 1]: begin
          plen_r <= {plen_r[23:0], wr.data};
        end
        [rpcd_pkg::OFS_TIMEOUT : rpcd_pkg::OFS_TIMEOUT + 3]: begin
          tmo_r <= {tmo_r[23:0], wr.data};
        end
        [rpcd_pkg::OFS_REQID : rpcd_pkg::HDR_BYTES - 1]: begin
          rid_r <= {rid_r[47:0], wr.data};
        end
        default: ;
      endcase
    end
  end

  assign mlen_bad = cfg.mode ? (mlen_r != 32'd0)
                             : ((mlen_r == 32'd0) || (mlen_r > cfg.max_method_len));

  always_comb begin
    res              = '0;
    // last header word is the low byte of the request id, used straight off the input
    res.call_id      = {rid_r, wr.data};
    res.deadline     = cfg.mode ? 32'd0 : tmo_r;
    res.reply_status = cfg.mode ? status_r : 16'd0;
    res.serial_type  = serial_r;
    res.method_len   = mlen_r;
    res.payload_len  = plen_r;
    if (magic_r != cfg.magic_word) begin
      res.err = rpcd_pkg::ERR_MAGIC;
    end else if (version_r != cfg.version_code) begin
      res.err = rpcd_pkg::ERR_VERSION;
    end else if (type_r != cfg.expected_type) begin
      res.err = rpcd_pkg::ERR_TYPE;
    end else if ((serial_r != cfg.serial_code_a) && (serial_r != cfg.serial_code_b)) begin
      res.err = rpcd_pkg::ERR_SERIAL;
    end else if (mlen_bad) begin
      res.err = rpcd_pkg::ERR_METHOD;
    end else if (plen_r > cfg.max_payload_len) begin
      res.err = rpcd_pkg::ERR_PAYLOAD;
    end else begin
      res.err = rpcd_pkg::ERR_NONE;
    end
  end

endmodule

[rtl/core/rpc_frame_deframer.sv]
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// byte-serial rpc frame deframer: header decode and check, body pass-through
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | in_byte
//   out_ch   | out | valid/ready        | kind, error_code, out_byte, last, header fields
//   cfg_*    | in  | cfg_we, no ready   | cfg_index, cfg_data
//
// one word accepted per clock; its result, if any, is valid on the next clock
// in_ch.ready drops only while the result register is full and out_ch.ready is low
// rst_n is synchronous; no memory clearing pass, the block is ready right after reset
// after an error words are accepted and dropped until reset
// ----------------------------------------------------------------------------
`include "rpc_frame_deframer_macros.svh"

module rpc_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  rpcd_in_if.sink     in_ch,
  rpcd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW = rpcd_pkg::CNT_W;

  rpcd_pkg::cfg_t     cfg_r;
  rpcd_pkg::phase_t   phase_r, phase_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [31:0]        mleft_r, mleft_nxt;
  logic [31:0]        pleft_r, pleft_nxt;
  logic               out_vld_r, out_vld_nxt;
  rpcd_pkg::res_t     res_r, res_nxt;
  logic               res_vld;
  logic               accept;
  rpcd_pkg::hdr_wr_t  hdr_wr;
  rpcd_pkg::hdr_res_t hdr_res;

  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_word      <= rpcd_pkg::RST_MAGIC;
      cfg_r.version_code    <= rpcd_pkg::RST_VERSION;
      cfg_r.expected_type   <= rpcd_pkg::RST_TYPE;
      cfg_r.mode            <= rpcd_pkg::RST_MODE;
      cfg_r.max_method_len  <= rpcd_pkg::RST_MAX_METH;
      cfg_r.max_payload_len <= rpcd_pkg::RST_MAX_PAYLD;
      cfg_r.serial_code_a   <= rpcd_pkg::RST_SERIAL_A;
      cfg_r.serial_code_b   <= rpcd_pkg::RST_SERIAL_B;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpcd_pkg::CFG_MAGIC:     cfg_r.magic_word      <= cfg_data;
        rpcd_pkg::CFG_VERSION:   cfg_r.version_code    <= cfg_data[7:0];
        rpcd_pkg::CFG_TYPE:      cfg_r.expected_type   <= cfg_data[7:0];
        rpcd_pkg::CFG_MODE:      cfg_r.mode            <= cfg_data[0];
        rpcd_pkg::CFG_MAX_METH:  cfg_r.max_method_len  <= cfg_data;
        rpcd_pkg::CFG_MAX_PAYLD: cfg_r.max_payload_len <= cfg_data;
        rpcd_pkg::CFG_SERIAL_A:  cfg_r.serial_code_a   <= cfg_data[7:0];
        rpcd_pkg::CFG_SERIAL_B:  cfg_r.serial_code_b   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign hdr_wr.load = accept && (phase_r == rpcd_pkg::PH_HEADER);
  assign hdr_wr.idx  = cnt_r;
  assign hdr_wr.data = in_ch.in_byte;

  rpcd_hdr u_hdr (
    .clk (clk),
    .cfg (cfg_r),
    .wr  (hdr_wr),
    .res (hdr_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= rpcd_pkg::PH_HEADER;
      cnt_r     <= '0;
      mleft_r   <= '0;
      pleft_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      mleft_r   <= mleft_nxt;
      pleft_r   <= pleft_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    mleft_nxt = mleft_r;
    pleft_nxt = pleft_r;
    res_vld   = 1'b0;
    res_nxt   = '0;
    unique case (phase_r)
      rpcd_pkg::PH_HEADER: begin
        if (accept) begin
          if (cnt_r == CW'(rpcd_pkg::HDR_BYTES - 1)) begin
            cnt_nxt = '0;
            res_vld = 1'b1;
            if (hdr_res.err != rpcd_pkg::ERR_NONE) begin
              res_nxt.kind       = rpcd_pkg::KIND_ERROR;
              res_nxt.error_code = hdr_res.err;
              phase_nxt          = rpcd_pkg::PH_HALT;
            end else begin
              res_nxt.kind         = rpcd_pkg::KIND_HDR;
              res_nxt.error_code   = rpcd_pkg::ERR_NONE;
              res_nxt.call_id      = hdr_res.call_id;
              res_nxt.deadline     = hdr_res.deadline;
              res_nxt.reply_status = hdr_res.reply_status;
              res_nxt.serial_type  = hdr_res.serial_type;
              res_nxt.method_len   = hdr_res.method_len;
              res_nxt.payload_len  = hdr_res.payload_len;
              res_nxt.last         = (hdr_res.method_len == 32'd0) &&
                                     (hdr_res.payload_len == 32'd0);
              mleft_nxt = hdr_res.method_len;
              pleft_nxt = hdr_res.payload_len;
              if (hdr_res.method_len != 32'd0) begin
                phase_nxt = rpcd_pkg::PH_METHOD;
              end else if (hdr_res.payload_len != 32'd0) begin
                phase_nxt = rpcd_pkg::PH_PAYLOAD;
              end else begin
                phase_nxt = rpcd_pkg::PH_HEADER;
              end
            end
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      rpcd_pkg::PH_METHOD: begin
        if (accept) begin
          res_vld          = 1'b1;
          res_nxt.kind     = rpcd_pkg::KIND_METHOD;
          res_nxt.out_byte = in_ch.in_byte;
          mleft_nxt        = mleft_r - 32'd1;
          if (mleft_r == 32'd1) begin
            phase_nxt    = (pleft_r != 32'd0) ? rpcd_pkg::PH_PAYLOAD : rpcd_pkg::PH_HEADER;
            res_nxt.last = (pleft_r == 32'd0);
          end
        end
      end
      rpcd_pkg::PH_PAYLOAD: begin
        if (accept) begin
          res_vld          = 1'b1;
          res_nxt.kind     = rpcd_pkg::KIND_PAYLOAD;
          res_nxt.out_byte = in_ch.in_byte;
          pleft_nxt        = pleft_r - 32'd1;
          if (pleft_r == 32'd1) begin
            phase_nxt    = rpcd_pkg::PH_HEADER;
            res_nxt.last = 1'b1;
          end
        end
      end
      rpcd_pkg::PH_HALT: ;
      default: ;
    endcase
    out_vld_nxt = res_vld || (out_vld_r && !out_ch.ready);
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.error_code   = res_r.error_code;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.last         = res_r.last;
  assign out_ch.call_id      = res_r.call_id;
  assign out_ch.deadline     = res_r.deadline;
  assign out_ch.reply_status = res_r.reply_status;
  assign out_ch.serial_type  = res_r.serial_type;
  assign out_ch.method_len   = res_r.method_len;
  assign out_ch.payload_len  = res_r.payload_len;

  `RPCD_ASSERT_NEXT(a_halt_sticks, phase_r == rpcd_pkg::PH_HALT, phase_r == rpcd_pkg::PH_HALT, "left halt without reset")
  `RPCD_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CW'(rpcd_pkg::HDR_BYTES - 1), "header count out of range")
  `RPCD_ASSERT_IMPL(a_method_left, phase_r == rpcd_pkg::PH_METHOD, mleft_r != 32'd0, "method phase with nothing left")
  `RPCD_ASSERT_IMPL(a_payload_left, phase_r == rpcd_pkg::PH_PAYLOAD, pleft_r != 32'd0, "payload phase with nothing left")
  `RPCD_ASSERT_NEXT(a_halt_silent, phase_r == rpcd_pkg::PH_HALT && !(out_vld_r && !out_ch.ready), !out_vld_r, "result after error")

endmodule
